### rtl/integer_cumulative_scan_macros.svh
// Assertion helpers for the cumulative scan block.
`ifndef INTEGER_CUMULATIVE_SCAN_MACROS_SVH
`define INTEGER_CUMULATIVE_SCAN_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ICS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ics assertion failed");

`define ICS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ics assertion failed");

`else

`define ICS_ASSERT_ALWAYS(lbl, clk, rst_n, expr)

`define ICS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/ics_pkg.sv
package ics_pkg;

    localparam logic [1:0] OP_SUM = 2'd0;
    localparam logic [1:0] OP_MAX = 2'd1;
    localparam logic [1:0] OP_MIN = 2'd2;

    localparam logic signed [31:0] INT_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT_NEG_MAX = 32'sh8000_0001;
    localparam logic signed [31:0] INT_MIN     = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] value;
        logic               first;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result;
        logic               overflow;
        logic               result_last;
    } t_out_item;

endpackage

### rtl/ics_stream_if.sv
interface ics_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/ics_in_stage.sv
module ics_in_stage (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ics_stream_if.sink   i_in,
    ics_stream_if.source o_out
);

    logic             r_valid;
    ics_pkg::t_in_item r_data;

    assign i_in.ready  = !r_valid || o_out.ready;
    assign o_out.valid = r_valid;
    assign o_out.data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_data <= i_in.data;
        end
    end

endmodule

### rtl/ics_scan_core.sv
module ics_scan_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ics_stream_if.sink   i_in,
    ics_stream_if.source o_out
);

    logic                r_valid;
    ics_pkg::t_out_item  r_data;
    logic signed [31:0]  r_acc;
    logic                r_miss;
    logic [1:0]          r_op;

    logic signed [31:0]  n_acc;
    logic                n_miss;
    logic [1:0]          n_op;
    ics_pkg::t_out_item  n_data;

    logic signed [31:0]  acc0;
    logic                miss0;
    logic signed [32:0]  sum;
    logic                sum_ovf;
    logic                accept;

    assign i_in.ready  = !r_valid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_out.valid = r_valid;
    assign o_out.data  = r_data;

    always_comb begin
        if (i_in.data.first) begin
            n_op  = i_in.data.func;
            miss0 = 1'b0;
            case (i_in.data.func)
                ics_pkg::OP_MAX: acc0 = ics_pkg::INT_MIN;
                ics_pkg::OP_MIN: acc0 = ics_pkg::INT_MAX;
                default:         acc0 = '0;
            endcase
        end else begin
            n_op  = r_op;
            miss0 = r_miss;
            acc0  = r_acc;
        end

        sum     = {acc0[31], acc0} + {i_in.data.value[31], i_in.data.value};
        sum_ovf = (sum[32] != sum[31]) || (sum[31:0] == ics_pkg::INT_MIN);

        n_miss          = miss0 || (i_in.data.value == ics_pkg::INT_MIN);
        n_acc           = acc0;
        n_data.overflow = 1'b0;
        case (n_op)
            ics_pkg::OP_SUM: begin
                if (!n_miss) begin
                    if (sum_ovf) begin
                        n_miss          = 1'b1;
                        n_data.overflow = 1'b1;
                    end else begin
                        n_acc = sum[31:0];
                    end
                end
            end
            ics_pkg::OP_MAX: begin
                if (!n_miss && (i_in.data.value > acc0)) begin
                    n_acc = i_in.data.value;
                end
            end
            ics_pkg::OP_MIN: begin
                if (!n_miss && (i_in.data.value < acc0)) begin
                    n_acc = i_in.data.value;
                end
            end
            default: begin
                n_miss = 1'b1;
            end
        endcase

        n_data.result      = n_miss ? ics_pkg::INT_MIN : n_acc;
        n_data.result_last = i_in.data.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_acc   <= '0;
            r_miss  <= 1'b0;
            r_op    <= ics_pkg::OP_SUM;
        end else begin
            if (i_in.ready) begin
                r_valid <= i_in.valid;
            end
            if (accept) begin
                r_acc  <= n_acc;
                r_miss <= n_miss;
                r_op   <= n_op;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= n_data;
        end
    end

endmodule

### rtl/integer_cumulative_scan.sv
// Running sum, maximum or minimum over a stream of signed 32-bit vector
// elements, one result item per input item. The operation is taken from func
// on the item marked first; INT_MIN in or out means missing, and a sum outside
// INT_NEG_MAX to INT_MAX goes missing with overflow set on that item only. The
// block takes one item every cycle while the output is not stalled; a result
// passes an input register, then one 33-bit add or signed compare against
// the accumulator feeding the result register. The accumulator loop closes
// within the core stage. Output stalls back up through both registers.
`include "integer_cumulative_scan_macros.svh"

module integer_cumulative_scan (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ics_stream_if.sink   i_in,
    ics_stream_if.source o_out
);

    ics_stream_if #(.T(ics_pkg::t_in_item)) s_mid ();

    ics_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (s_mid.source)
    );

    ics_scan_core u_scan_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (s_mid.sink),
        .o_out   (o_out)
    );

    `ICS_ASSERT_ALWAYS(a_ovf_missing, i_clk, i_rst_n, !(o_out.valid && o_out.data.overflow) || (o_out.data.result == ics_pkg::INT_MIN))

    `ICS_ASSERT_NEXT(a_mid_hold, i_clk, i_rst_n, s_mid.valid && o_out.valid && !o_out.ready, s_mid.valid && $stable(s_mid.data))

    `ICS_ASSERT_ALWAYS(a_in_ready, i_clk, i_rst_n, i_in.ready == (!s_mid.valid || !o_out.valid || o_out.ready))

endmodule

### verif/ics_scan_checker.sv
module ics_scan_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  ics_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  ics_pkg::t_out_item i_out_data,
    output int                 o_mismatch_count,
    output int                 o_results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    ics_pkg::t_out_item owed_q[$];
    logic signed [31:0] scan_acc;
    logic               scan_missing;
    logic [1:0]         scan_op;
    int                 mismatches;

    initial begin
        o_mismatch_count = 0;
        o_results_owed   = 0;
        mismatches       = 0;
        scan_acc         = '0;
        scan_missing     = 1'b0;
        scan_op          = ics_pkg::OP_SUM;
    end

    // Advances the running scan by one element and returns its result item.
    function automatic ics_pkg::t_out_item scan_step(ics_pkg::t_in_item it);
        ics_pkg::t_out_item r;
        longint             total;
        r.result      = ics_pkg::INT_MIN;
        r.overflow    = 1'b0;
        r.result_last = it.last;
        if (it.first) begin
            scan_op      = it.func;
            scan_missing = 1'b0;
            case (it.func)
                ics_pkg::OP_MAX: scan_acc = ics_pkg::INT_MIN;
                ics_pkg::OP_MIN: scan_acc = ics_pkg::INT_MAX;
                default:         scan_acc = '0;
            endcase
        end
        if (scan_op > ics_pkg::OP_MIN || it.value == ics_pkg::INT_MIN)
            scan_missing = 1'b1;
        if (!scan_missing) begin
            case (scan_op)
                ics_pkg::OP_SUM: begin
                    total = longint'($signed(scan_acc)) + longint'($signed(it.value));
                    if (total > longint'(ics_pkg::INT_MAX)
                            || total < longint'(ics_pkg::INT_NEG_MAX)) begin
                        scan_missing = 1'b1;
                        r.overflow   = 1'b1;
                    end else begin
                        scan_acc = total[31:0];
                    end
                end
                ics_pkg::OP_MAX: if ($signed(it.value) > $signed(scan_acc)) scan_acc = it.value;
                default: if ($signed(it.value) < $signed(scan_acc)) scan_acc = it.value;
            endcase
            if (!scan_missing)
                r.result = scan_acc;
        end
        return r;
    endfunction

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        ics_pkg::t_out_item want;
        if (!i_rst_n) begin
            scan_acc     = '0;
            scan_missing = 1'b0;
            scan_op      = ics_pkg::OP_SUM;
            owed_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (owed_q.size() == 0) begin
                    note_failure($sformatf(
                        "result item with none owed: result %0d ovf %0b last %0b",
                        i_out_data.result, i_out_data.overflow, i_out_data.result_last));
                end else begin
                    want = owed_q.pop_front();
                    if (want.result !== i_out_data.result
                            || want.overflow !== i_out_data.overflow
                            || want.result_last !== i_out_data.result_last)
                        note_failure($sformatf(
                            "mismatch: exp result %0d ovf %0b last %0b, got %0d ovf %0b last %0b",
                            want.result, want.overflow, want.result_last,
                            i_out_data.result, i_out_data.overflow, i_out_data.result_last));
                end
            end
            if (i_in_valid && i_in_ready)
                owed_q.push_back(scan_step(i_in_data));
        end
        o_results_owed   <= owed_q.size();
        o_mismatch_count <= mismatches;
    end

endmodule

### verif/tb_integer_cumulative_scan.sv
module tb_integer_cumulative_scan;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam int         N_ITEMS    = 1300;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic i_clk;
    logic i_rst_n;
    int   mismatch_count;
    int   results_owed;
    int   burst_left;

    t_rx_mode rx_mode;
    int       rx_left;
    int       rx_phase;

    ics_stream_if #(.T(ics_pkg::t_in_item))  in_if ();
    ics_stream_if #(.T(ics_pkg::t_out_item)) out_if ();

    integer_cumulative_scan dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    ics_scan_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_if.valid),
        .i_in_ready       (in_if.ready),
        .i_in_data        (in_if.data),
        .i_out_valid      (out_if.valid),
        .i_out_ready      (out_if.ready),
        .i_out_data       (out_if.data),
        .o_mismatch_count (mismatch_count),
        .o_results_owed   (results_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        out_if.ready = 1'b0;
        rx_mode      = RX_OPEN;
        rx_left      = 0;
        rx_phase     = 0;
    end

    // Receiver backpressure: switches between open, coin-flip, sparse and periodic stalls.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_OPEN:   out_if.ready <= 1'b1;
            RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
            default:   out_if.ready <= (rx_phase % 5 != 0) && (rx_phase % 7 != 0);
        endcase
    end

    task automatic drive_item(input logic [1:0] f, input logic signed [31:0] v,
                              input logic fst, input logic lst);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= ics_pkg::t_in_item'{func: f, value: v, first: fst, last: lst};
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        burst_left--;
    endtask

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)  return ics_pkg::INT_MIN;
        if (r < 40) return 32'($signed($urandom_range(0, 200)) - 100);
        if (r < 60) return $urandom;
        if (r < 75) return ics_pkg::INT_MAX - 32'($urandom_range(0, 1000));
        if (r < 90) return ics_pkg::INT_NEG_MAX + 32'($urandom_range(0, 1000));
        return $signed($urandom) >>> 1;
    endfunction

    initial begin
        int         sent;
        int         len;
        logic [1:0] op;
        logic       broken;
        logic       fst;
        logic       lst;

        i_rst_n     = 1'b0;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        burst_left  = 0;
        sent        = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // items before any first: summed from the reset state
        drive_item(ics_pkg::OP_MAX, 32'sd5, 1'b0, 1'b0);
        drive_item(ics_pkg::OP_MIN, -32'sd1, 1'b0, 1'b1);
        // positive overflow, then stays missing
        drive_item(ics_pkg::OP_SUM, ics_pkg::INT_MAX, 1'b1, 1'b0);
        drive_item(ics_pkg::OP_SUM, 32'sd1, 1'b0, 1'b0);
        drive_item(ics_pkg::OP_SUM, 32'sd7, 1'b0, 1'b1);
        // negative overflow
        drive_item(ics_pkg::OP_SUM, ics_pkg::INT_NEG_MAX, 1'b1, 1'b0);
        drive_item(ics_pkg::OP_SUM, -32'sd1, 1'b0, 1'b1);
        // missing input in a sum
        drive_item(ics_pkg::OP_SUM, 32'sd0, 1'b1, 1'b0);
        drive_item(ics_pkg::OP_SUM, ics_pkg::INT_MIN, 1'b0, 1'b0);
        drive_item(ics_pkg::OP_SUM, 32'sd3, 1'b0, 1'b1);
        // missing on the first element of a max
        drive_item(ics_pkg::OP_MAX, ics_pkg::INT_MIN, 1'b1, 1'b0);
        drive_item(ics_pkg::OP_MAX, 32'sd4, 1'b0, 1'b1);
        // max, then an item after last without first
        drive_item(ics_pkg::OP_MAX, -32'sd7, 1'b1, 1'b0);
        drive_item(ics_pkg::OP_MAX, ics_pkg::INT_MAX, 1'b0, 1'b0);
        drive_item(ics_pkg::OP_MAX, 32'sd3, 1'b0, 1'b1);
        drive_item(ics_pkg::OP_MIN, 32'sd100, 1'b0, 1'b1);
        // min with extremes and a missing item
        drive_item(ics_pkg::OP_MIN, ics_pkg::INT_MAX, 1'b1, 1'b0);
        drive_item(ics_pkg::OP_MIN, ics_pkg::INT_NEG_MAX, 1'b0, 1'b0);
        drive_item(ics_pkg::OP_MIN, 32'sd0, 1'b0, 1'b0);
        drive_item(ics_pkg::OP_MIN, ics_pkg::INT_MIN, 1'b0, 1'b0);
        drive_item(ics_pkg::OP_MIN, 32'sd5, 1'b0, 1'b1);
        // unknown operation
        drive_item(OP_UNKNOWN, 32'sd1, 1'b1, 1'b0);
        drive_item(ics_pkg::OP_SUM, 32'sd2, 1'b0, 1'b1);
        drive_item(ics_pkg::OP_SUM, -32'sd1000, 1'b1, 1'b0);
        drive_item(ics_pkg::OP_SUM, ics_pkg::INT_NEG_MAX, 1'b0, 1'b1);
        drive_item(ics_pkg::OP_MAX, 32'sd0, 1'b1, 1'b1);

        while (sent < N_ITEMS) begin
            len    = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
            op     = ($urandom_range(0, 9) == 0)
                     ? OP_UNKNOWN
                     : 2'($urandom_range(ics_pkg::OP_SUM, ics_pkg::OP_MIN));
            broken = ($urandom_range(0, 19) == 0);
            for (int k = 0; k < len; k++) begin
                fst = (k == 0) && !(broken && $urandom_range(0, 1));
                lst = (k == len - 1) && !(broken && $urandom_range(0, 1));
                drive_item((k == 0) ? op : 2'($urandom), pick_value(), fst, lst);
                sent++;
            end
        end
        in_if.valid <= 1'b0;

        @(posedge i_clk);
        while (results_owed != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### integer_cumulative_scan.f
+incdir+rtl
rtl/ics_pkg.sv
rtl/ics_stream_if.sv
rtl/ics_in_stage.sv
rtl/ics_scan_core.sv
rtl/integer_cumulative_scan.sv
verif/ics_scan_checker.sv
verif/tb_integer_cumulative_scan.sv
